// ===== rtl/core/psrr_pkg.sv =====
// Shared types and constants for the pending-signal round-robin controller.
`timescale 1ns / 1ps
`default_nettype none

package psrr_pkg;

   // Default sizing of the pending-count store.
   localparam int NUM_SOURCES_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 16;

   // Fixed width of the running total and depth of the queue between the two halves.
   localparam int TOTAL_WIDTH = 20;
   localparam int QUEUE_DEPTH = 2;

   // Encodings of the request kind field.
   localparam logic [1:0] KIND_RAISE   = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_RETURN  = 2'd2;
   localparam logic [1:0] KIND_CONTEXT = 2'd3;

   // Operation as classified by the front end.
   typedef enum logic [2:0] {
      OP_RAISE,
      OP_DROP,
      OP_ACK,
      OP_RETURN,
      OP_CONTEXT
   } op_type;

   // One queued operation.
   typedef struct packed {
      op_type     op;
      logic [3:0] source;
      logic       running_code;
      logic       mask_all;
      logic       io_waiting;
   } entry_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/psrr_front.sv =====
// Front end: holds the enable mask, accepts request words and classifies them.
`timescale 1ns / 1ps
`default_nettype none

module psrr_front
   import psrr_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_kind,
   input  wire logic [3:0]       req_source,
   input  wire logic             req_running_code,
   input  wire logic             req_mask_all,
   input  wire logic             req_io_waiting,
   input  wire queue_status_type q_status,
   output logic                  push,
   output entry_type             push_entry
);

   logic [15:0] enable_mask_ff;
   logic [15:0] enable_mask_in;
   logic        in_range;

   assign enable_mask_in = csr_we ? csr_wdata : enable_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= '0;
      end else begin
         enable_mask_ff <= enable_mask_in;
      end
   end

   assign in_range  = 32'(req_source) < NUM_SOURCES;
   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_entry.source       = req_source;
      push_entry.running_code = req_running_code;
      push_entry.mask_all     = req_mask_all;
      push_entry.io_waiting   = req_io_waiting;
      case (req_kind)
         KIND_RAISE: begin
            push_entry.op = (in_range && enable_mask_ff[req_source]) ? OP_RAISE : OP_DROP;
         end
         KIND_ACK:     push_entry.op = OP_ACK;
         KIND_RETURN:  push_entry.op = OP_RETURN;
         KIND_CONTEXT: push_entry.op = OP_CONTEXT;
         default:      push_entry.op = OP_DROP;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/psrr_queue.sv =====
// Short queue of classified operations between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module psrr_queue
   import psrr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire entry_type        push_entry,
   input  wire logic             pop,
   output logic                  pop_valid,
   output entry_type             pop_entry,
   output queue_status_type      q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign q_status.full  = fill_ff == CNT_W'(QUEUE_DEPTH);
   assign q_status.empty = fill_ff == '0;
   assign pop_valid      = !q_status.empty;
   assign pop_entry      = slots_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/psrr_back.sv =====
// Back end: pending-count memory, round-robin pick, flags and the response register.
`timescale 1ns / 1ps
`default_nettype none

module psrr_back
   import psrr_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire entry_type              q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_counted,
   output logic                        rsp_trap_request,
   output logic                        rsp_wake_io,
   output logic [3:0]                  rsp_sig_code,
   output logic [15:0]                 rsp_sig_count,
   output logic                        rsp_none_pending,
   output logic [TOTAL_WIDTH-1:0]      rsp_total_pending
);

   localparam int IDX_W = $clog2(NUM_SOURCES);
   localparam int CMP_W = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      ST_ISSUE  = 2'b01,
      ST_FINISH = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   entry_type               cur_ff;
   logic [IDX_W-1:0]        addr_ff;
   logic                    found_ff;
   logic [COUNT_WIDTH-1:0]  rd_data_ff;
   logic [COUNT_WIDTH-1:0]  mem_ff [NUM_SOURCES];
   logic [NUM_SOURCES-1:0]  nz_ff, nz_in;
   logic [TOTAL_WIDTH-1:0]  total_ff, total_in;
   logic [IDX_W-1:0]        last_ff, last_in;
   logic                    trap_armed_ff, trap_armed_in;
   logic                    handler_ff, handler_in;
   logic                    in_code_ff, in_code_in;
   logic                    masked_ff, masked_in;
   logic                    io_wait_ff, io_wait_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    counted_ff, counted_in;
   logic                    trap_ff, trap_in;
   logic                    wake_ff, wake_in;
   logic [3:0]              code_ff, code_in;
   logic [15:0]             count_ff, count_in;
   logic                    none_ff, none_in;

   logic [NUM_SOURCES-1:0]  hi_mask, cand, sel, onehot;
   logic [IDX_W-1:0]        pick_idx, issue_addr;
   logic [COUNT_WIDTH-1:0]  cur_count;
   logic                    finish;
   logic                    mem_we;
   logic [COUNT_WIDTH-1:0]  mem_wdata;

   // Round-robin pick: lowest nonzero entry above the last served, else lowest overall.
   always_comb begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
         hi_mask[i] = IDX_W'(i) > last_ff;
      end
      cand     = nz_ff & hi_mask;
      sel      = (cand != '0) ? cand : nz_ff;
      onehot   = sel & (~sel + NUM_SOURCES'(1));
      pick_idx = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         pick_idx = pick_idx | (onehot[i] ? IDX_W'(i) : '0);
      end
   end

   assign issue_addr = (q_entry.op == OP_ACK) ? pick_idx : IDX_W'(q_entry.source);
   assign q_pop      = (state_ff == ST_ISSUE) && q_valid;
   assign finish     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign cur_count  = nz_ff[addr_ff] ? rd_data_ff : '0;

   always_comb begin
      state_in      = state_ff;
      nz_in         = nz_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      trap_armed_in = trap_armed_ff;
      handler_in    = handler_ff;
      in_code_in    = in_code_ff;
      masked_in     = masked_ff;
      io_wait_in    = io_wait_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      counted_in    = counted_ff;
      trap_in       = trap_ff;
      wake_in       = wake_ff;
      code_in       = code_ff;
      count_in      = count_ff;
      none_in       = none_ff;
      mem_we        = 1'b0;
      mem_wdata     = cur_count + COUNT_WIDTH'(1);

      case (state_ff)
         ST_ISSUE: begin
            if (q_valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in     = ST_ISSUE;
               rsp_valid_in = 1'b1;
               counted_in   = 1'b0;
               trap_in      = 1'b0;
               wake_in      = 1'b0;
               code_in      = '0;
               count_in     = '0;
               none_in      = 1'b0;
               case (cur_ff.op)
                  OP_RAISE: begin
                     counted_in = 1'b1;
                     if (cur_count != COUNT_MAX) begin
                        mem_we         = 1'b1;
                        nz_in[addr_ff] = 1'b1;
                        if (total_ff != TOTAL_MAX) begin
                           total_in = total_ff + TOTAL_WIDTH'(1);
                        end
                     end
                     if (!masked_ff) begin
                        if (io_wait_ff) begin
                           wake_in = 1'b1;
                        end else if (in_code_ff && !trap_armed_ff && !handler_ff) begin
                           trap_armed_in = 1'b1;
                           trap_in       = 1'b1;
                        end
                     end
                  end
                  OP_ACK: begin
                     if (found_ff) begin
                        last_in        = addr_ff;
                        nz_in[addr_ff] = 1'b0;
                        if (CMP_W'(cur_count) >= CMP_W'(total_ff)) begin
                           total_in = '0;
                        end else begin
                           total_in = total_ff - TOTAL_WIDTH'(cur_count);
                        end
                        trap_armed_in = 1'b0;
                        handler_in    = 1'b1;
                        code_in       = 4'(addr_ff);
                        count_in      = 16'(cur_count);
                     end else begin
                        none_in = 1'b1;
                     end
                  end
                  OP_RETURN: begin
                     handler_in = 1'b0;
                  end
                  OP_CONTEXT: begin
                     in_code_in = cur_ff.running_code;
                     masked_in  = cur_ff.mask_all;
                     io_wait_in = cur_ff.io_waiting;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ISSUE;
         nz_ff         <= '0;
         total_ff      <= '0;
         last_ff       <= '0;
         trap_armed_ff <= 1'b0;
         handler_ff    <= 1'b0;
         in_code_ff    <= 1'b0;
         masked_ff     <= 1'b0;
         io_wait_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nz_ff         <= nz_in;
         total_ff      <= total_in;
         last_ff       <= last_in;
         trap_armed_ff <= trap_armed_in;
         handler_ff    <= handler_in;
         in_code_ff    <= in_code_in;
         masked_ff     <= masked_in;
         io_wait_ff    <= io_wait_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      counted_ff <= counted_in;
      trap_ff    <= trap_in;
      wake_ff    <= wake_in;
      code_ff    <= code_in;
      count_ff   <= count_in;
      none_ff    <= none_in;
      if (q_pop) begin
         cur_ff     <= q_entry;
         addr_ff    <= issue_addr;
         found_ff   <= nz_ff != '0;
         rd_data_ff <= mem_ff[issue_addr];
      end
   end

   // Count memory; an entry whose nonzero bit is clear reads as zero.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[addr_ff] <= mem_wdata;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counted       = counted_ff;
   assign rsp_trap_request  = trap_ff;
   assign rsp_wake_io       = wake_ff;
   assign rsp_sig_code      = code_ff;
   assign rsp_sig_count     = count_ff;
   assign rsp_none_pending  = none_ff;
   assign rsp_total_pending = total_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pending_signal_round_robin.sv =====
// Top level of the pending-signal controller with round-robin acknowledge.
//
//   Channel  Direction  Handshake             Contents
//   req_     in         req_valid/req_ready   kind, source, context flags
//   rsp_     out        rsp_valid/rsp_ready   raise, acknowledge and total results
//   csr_     in         csr_we (no wait)      16-bit source enable mask
//
// Each word passes through the back-end states ISSUE, which picks the address and
// reads the count memory, and FINISH, which updates state and loads the response
// register; the back end takes a new word only after it has finished the last.
// Reset is synchronous and active high; it clears the context, trap and handler flags, the total and the
// nonzero bits of the count memory, so no clearing pass is needed.
// A stalled response holds the back end; the two-word queue keeps req_ready high
// until it fills.
`timescale 1ns / 1ps
`default_nettype none

module pending_signal_round_robin
   import psrr_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [15:0]            csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_kind,
   input  wire logic [3:0]             req_source,
   input  wire logic                   req_running_code,
   input  wire logic                   req_mask_all,
   input  wire logic                   req_io_waiting,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_counted,
   output logic                        rsp_trap_request,
   output logic                        rsp_wake_io,
   output logic [3:0]                  rsp_sig_code,
   output logic [15:0]                 rsp_sig_count,
   output logic                        rsp_none_pending,
   output logic [TOTAL_WIDTH-1:0]      rsp_total_pending
);

   // Front end to queue.
   logic             push;
   entry_type        push_entry;
   queue_status_type q_status;

   // Queue to back end.
   logic             pop;
   logic             pop_valid;
   entry_type        pop_entry;

   // The front end owns the enable mask and turns disabled or out-of-range raises
   // into drops, so the back end never writes the count memory for them.
   psrr_front #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_source       (req_source),
      .req_running_code (req_running_code),
      .req_mask_all     (req_mask_all),
      .req_io_waiting   (req_io_waiting),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   // Decouples acceptance from execution so a stalled response does not block
   // the request side until the queue is full.
   psrr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // The back end holds the counts and flags and executes one word at a time.
   psrr_back #(
      .NUM_SOURCES (NUM_SOURCES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (pop_valid),
      .q_entry           (pop_entry),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_counted       (rsp_counted),
      .rsp_trap_request  (rsp_trap_request),
      .rsp_wake_io       (rsp_wake_io),
      .rsp_sig_code      (rsp_sig_code),
      .rsp_sig_count     (rsp_sig_count),
      .rsp_none_pending  (rsp_none_pending),
      .rsp_total_pending (rsp_total_pending)
   );

`ifndef SYNTHESIS
   // A trap request and an I/O wake both come only from a counted raise.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_trap_request || rsp_wake_io) |-> rsp_counted)
      else $error("trap or wake reported without a counted raise");

   // A raise may wake the I/O wait or arm a trap, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_trap_request && rsp_wake_io))
      else $error("trap request and I/O wake reported together");

   // An empty acknowledge reports no code, no count and no counted raise.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_pending |-> rsp_sig_code == 4'd0 && rsp_sig_count == 16'd0
         && !rsp_counted)
      else $error("empty acknowledge carries a code or count");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_pending_signal_round_robin.sv =====
// Self-checking testbench for the pending-signal round-robin controller.
`timescale 1ns / 1ps

module tb_pending_signal_round_robin;
   import psrr_pkg::*;

   // A result word is sampled at a rising edge; the back end and the two-word queue
   // settle well within this window.
   localparam int SETTLE_CYCLES  = 8;
   // The receiver's long hold-off, and the number of quiet cycles that ends the run.
   localparam int HOLDOFF_CYCLES = 200;
   localparam int QUIET_LIMIT    = 2000;
   localparam logic [15:0]            COUNT_MAX = 16'hFFFF;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};
   localparam int PHASE_WORDS    = 155;
   localparam int RUN_RAISES     = 40;

   // One request word as the sender presents it.
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] source;
      logic       running_code;
      logic       mask_all;
      logic       io_waiting;
   } signal_word_type;

   // One response word as the block should return it.
   typedef struct packed {
      logic                   counted;
      logic                   trap_request;
      logic                   wake_io;
      logic [3:0]             sig_code;
      logic [15:0]            sig_count;
      logic                   none_pending;
      logic [TOTAL_WIDTH-1:0] total_pending;
   } signal_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [15:0]            csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_kind;
   logic [3:0]             req_source;
   logic                   req_running_code;
   logic                   req_mask_all;
   logic                   req_io_waiting;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_counted;
   logic                   rsp_trap_request;
   logic                   rsp_wake_io;
   logic [3:0]             rsp_sig_code;
   logic [15:0]            rsp_sig_count;
   logic                   rsp_none_pending;
   logic [TOTAL_WIDTH-1:0] rsp_total_pending;

   pending_signal_round_robin dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_source        (req_source),
      .req_running_code  (req_running_code),
      .req_mask_all      (req_mask_all),
      .req_io_waiting    (req_io_waiting),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_counted       (rsp_counted),
      .rsp_trap_request  (rsp_trap_request),
      .rsp_wake_io       (rsp_wake_io),
      .rsp_sig_code      (rsp_sig_code),
      .rsp_sig_count     (rsp_sig_count),
      .rsp_none_pending  (rsp_none_pending),
      .rsp_total_pending (rsp_total_pending)
   );

   // The predictor's own copy of the controller state. It starts at the reset
   // values, and reset is applied exactly once, so no separate clear is needed.
   logic [15:0]            src_pending [16] = '{default: '0};
   logic [TOTAL_WIDTH-1:0] pending_sum  = '0;
   logic [3:0]             prev_served  = '0;
   logic                   trap_set     = 1'b0;
   logic                   in_handler   = 1'b0;
   logic                   ctx_running  = 1'b0;
   logic                   ctx_masked   = 1'b0;
   logic                   ctx_io_wait  = 1'b0;
   logic [15:0]            src_enable   = '0;

   // Response words still owed by the block, oldest first.
   signal_result_type      awaited_results [$];

   int error_count = 0;
   int quiet_cycles = 0;

   // Knobs that the test tasks turn and the sender and receiver follow.
   int holdoffs_requested = 0;
   bit rsp_always_ready = 1'b0;
   bit pace_gaps = 1'b1;
   int burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one word to the predicted state and returns the response it causes.
   // A raise counts only for an enabled source; the counts saturate, and the
   // total grows only when the source count actually moved. The wake takes
   // priority over arming a trap, and neither happens while the context is masked.
   function automatic signal_result_type predict_signal_result(input signal_word_type w);
      signal_result_type r;
      logic [3:0]     idx;
      logic           found;
      logic [15:0]    taken;
      int             n;
      r = '0;
      case (w.kind)
         KIND_RAISE: begin
            if (src_enable[w.source]) begin
               r.counted = 1'b1;
               if (src_pending[w.source] != COUNT_MAX) begin
                  src_pending[w.source] = src_pending[w.source] + 16'd1;
                  if (pending_sum != TOTAL_MAX) pending_sum = pending_sum + 1'b1;
               end
               if (!ctx_masked) begin
                  if (ctx_io_wait) begin
                     r.wake_io = 1'b1;
                  end else if (ctx_running && !trap_set && !in_handler) begin
                     trap_set = 1'b1;
                     r.trap_request = 1'b1;
                  end
               end
            end
         end
         KIND_ACK: begin
            // The search starts just after the last source served and wraps once.
            idx = prev_served;
            found = 1'b0;
            for (n = 0; n < 16 && !found; n++) begin
               idx = idx + 4'd1;
               if (src_pending[idx] != '0) found = 1'b1;
            end
            if (found) begin
               taken = src_pending[idx];
               prev_served = idx;
               pending_sum = ({4'd0, taken} >= pending_sum) ? '0 : pending_sum - taken;
               src_pending[idx] = '0;
               trap_set = 1'b0;
               in_handler = 1'b1;
               r.sig_code = idx;
               r.sig_count = taken;
            end else begin
               r.none_pending = 1'b1;
            end
         end
         KIND_RETURN: begin
            in_handler = 1'b0;
         end
         default: begin
            ctx_running = w.running_code;
            ctx_masked = w.mask_all;
            ctx_io_wait = w.io_waiting;
         end
      endcase
      r.total_pending = pending_sum;
      return r;
   endfunction

   function automatic signal_word_type make_word(input logic [1:0] kind,
                                                 input logic [3:0] source,
                                                 input logic rc, input logic ma,
                                                 input logic iow);
      signal_word_type w;
      w.kind = kind;
      w.source = source;
      w.running_code = rc;
      w.mask_all = ma;
      w.io_waiting = iow;
      return w;
   endfunction

   function automatic signal_word_type random_word();
      signal_word_type w;
      w = signal_word_type'($urandom_range(0, 511));
      return w;
   endfunction

   // Every task below is entered just after a falling edge and returns just
   // after one, so all inputs change on falling edges only. send_word leaves
   // req_valid high on return; a following send simply replaces the payload,
   // and idle_sender, wait_for_results and set_enable_mask lower it first.
   task automatic send_word(input signal_word_type w);
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_source <= w.source;
      req_running_code <= w.running_code;
      req_mask_all <= w.mask_all;
      req_io_waiting <= w.io_waiting;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The word was taken at this edge; its response is now owed.
      awaited_results.push_back(predict_signal_result(w));
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Sends one word as part of a burst; a new burst may open with a random gap.
   task automatic send_paced(input signal_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = pace_gaps ? $urandom_range(0, 6) : 0;
         if (gap != 0) idle_sender(gap);
      end
      burst_left--;
      send_word(w);
   endtask

   // The sender pauses until every owed response has come back, then lets the
   // back end go quiet.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Only called while the block is idle.
   task automatic set_enable_mask(input logic [15:0] mask);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_wdata <= mask;
      src_enable = mask;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One handling episode: set the context, raise a few sources, acknowledge
   // them and usually return from the handler. Some noise follows now and then.
   task automatic send_episode(inout int words_sent);
      signal_word_type w;
      int raises;
      int acks;
      int noise;
      int k;
      w = random_word();
      w.kind = KIND_CONTEXT;
      w.running_code = ($urandom_range(0, 3) != 0);
      w.mask_all = ($urandom_range(0, 4) == 0);
      w.io_waiting = ($urandom_range(0, 4) == 0);
      send_paced(w);
      raises = $urandom_range(1, 6);
      for (k = 0; k < raises; k++) begin
         w = random_word();
         w.kind = KIND_RAISE;
         send_paced(w);
      end
      acks = $urandom_range(1, 3);
      for (k = 0; k < acks; k++) begin
         w = random_word();
         w.kind = KIND_ACK;
         send_paced(w);
      end
      words_sent += 1 + raises + acks;
      if ($urandom_range(0, 3) != 0) begin
         w = random_word();
         w.kind = KIND_RETURN;
         send_paced(w);
         words_sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
         noise = $urandom_range(1, 3);
         for (k = 0; k < noise; k++) send_paced(random_word());
         words_sent += noise;
      end
   endtask

   // Straight after reset the enable mask is zero: a raise is dropped, an
   // acknowledge finds nothing, and a return changes nothing visible.
   task automatic test_reset_state();
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_RAISE, 4'd15, 1'b1, 1'b1, 1'b1));
      send_word(make_word(KIND_RETURN, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_CONTEXT, 4'd0, 1'b1, 1'b0, 1'b0));
      send_word(make_word(KIND_RAISE, 4'd0, 1'b0, 1'b0, 1'b0));
      wait_for_results();
   endtask

   // Walks the trap, wake and handler flags with every source enabled, and
   // shows the round-robin order of the acknowledge.
   task automatic test_signal_handling();
      set_enable_mask(16'hFFFF);
      send_word(make_word(KIND_CONTEXT, 4'd0, 1'b1, 1'b0, 1'b0));
      send_word(make_word(KIND_RAISE, 4'd0, 1'b0, 1'b0, 1'b0));   // arms the trap
      send_word(make_word(KIND_RAISE, 4'd15, 1'b0, 1'b0, 1'b0));  // trap already armed
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));     // finds 15 first
      send_word(make_word(KIND_RAISE, 4'd3, 1'b0, 1'b0, 1'b0));   // handler active
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));     // nothing left
      send_word(make_word(KIND_RETURN, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_RAISE, 4'd13, 1'b0, 1'b0, 1'b0));  // arms again
      send_word(make_word(KIND_CONTEXT, 4'd0, 1'b1, 1'b0, 1'b1));
      send_word(make_word(KIND_RAISE, 4'd14, 1'b0, 1'b0, 1'b0));  // breaks the I/O wait
      send_word(make_word(KIND_CONTEXT, 4'd0, 1'b1, 1'b1, 1'b1));
      send_word(make_word(KIND_RAISE, 4'd15, 1'b0, 1'b0, 1'b0));  // masked: counted only
      send_word(make_word(KIND_CONTEXT, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_RAISE, 4'd15, 1'b0, 1'b0, 1'b0));  // not in code
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_RETURN, 4'd0, 1'b0, 1'b0, 1'b0));
      wait_for_results();
   endtask

   // Piles a long run of raises onto one source as fast as req_ready allows, with
   // the receiver always ready, then takes the whole count in one acknowledge.
   task automatic test_count_run();
      int k;
      rsp_always_ready = 1'b1;
      send_word(make_word(KIND_CONTEXT, 4'd0, 1'b1, 1'b0, 1'b0));
      for (k = 0; k < RUN_RAISES; k++) begin
         send_word(make_word(KIND_RAISE, 4'd7, 1'b1, 1'b0, 1'b0));
      end
      send_word(make_word(KIND_RAISE, 4'd9, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_ACK, 4'd0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(KIND_RETURN, 4'd0, 1'b0, 1'b0, 1'b0));
      wait_for_results();
      rsp_always_ready = 1'b0;
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // words, so the queue fills and req_ready must drop; nothing may be lost.
   task automatic test_output_backpressure();
      int words_sent;
      words_sent = 0;
      pace_gaps = 1'b0;
      holdoffs_requested++;
      @(negedge clock);
      while (words_sent < 24) send_episode(words_sent);
      wait_for_results();
      pace_gaps = 1'b1;
   endtask

   // Random episodes under several enable masks, zero and all-ones among them.
   // One phase runs without any idling; one pauses midway until all
   // responses are in.
   task automatic test_random_traffic();
      int phase;
      int words_sent;
      bit paused;
      logic [15:0] mask;
      paused = 1'b0;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: mask = 16'hFFFF;
            2: mask = 16'h0000;
            3: mask = 16'h8001;
            5: mask = 16'hFFFF;
            default: mask = 16'($urandom_range(0, 65535));
         endcase
         set_enable_mask(mask);
         rsp_always_ready = (phase == 4);
         pace_gaps = (phase != 4);
         words_sent = 0;
         while (words_sent < PHASE_WORDS) begin
            send_episode(words_sent);
            if (phase == 1 && !paused && words_sent >= PHASE_WORDS / 2) begin
               paused = 1'b1;
               wait_for_results();
            end
         end
         wait_for_results();
      end
      rsp_always_ready = 1'b0;
      pace_gaps = 1'b1;
   endtask

   // Receiver: runs of ready and stall of random length, an always-ready mode,
   // and the long hold-off, whose cycles are counted here.
   initial begin
      int go_run;
      int stall_run;
      int holdoffs_done;
      go_run = 0;
      stall_run = 0;
      holdoffs_done = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_done != holdoffs_requested) begin
            holdoffs_done++;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else if (rsp_always_ready) begin
            rsp_ready <= 1'b1;
         end else if (stall_run > 0) begin
            rsp_ready <= 1'b0;
            stall_run--;
         end else begin
            rsp_ready <= 1'b1;
            if (go_run > 0) begin
               go_run--;
            end else begin
               go_run = $urandom_range(0, 16);
               stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // Every accepted response word is checked against the oldest owed one.
   always @(posedge clock) begin : check_responses
      signal_result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: response word with none owed, expected nothing, actual total 0x%0h",
                     $time, rsp_total_pending);
         end else begin
            due = awaited_results.pop_front();
            compare_field("counted", due.counted, rsp_counted);
            compare_field("trap_request", due.trap_request, rsp_trap_request);
            compare_field("wake_io", due.wake_io, rsp_wake_io);
            compare_field("sig_code", due.sig_code, rsp_sig_code);
            compare_field("sig_count", due.sig_count, rsp_sig_count);
            compare_field("none_pending", due.none_pending, rsp_none_pending);
            compare_field("total_pending", due.total_pending, rsp_total_pending);
         end
      end
   end

   // Watchdog: too long with no word accepted on either side ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_kind = KIND_RAISE;
      req_source = '0;
      req_running_code = 1'b0;
      req_mask_all = 1'b0;
      req_io_waiting = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_signal_handling();
      test_count_run();
      test_output_backpressure();
      test_random_traffic();
      wait_for_results();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
